### rtl/core/vnoise_pkg.sv
package vnoise_pkg;

    // Default values of the top level parameters.
    localparam int MAX_OCTAVES_DEF    = 4;
    localparam int COS_TABLE_BITS_DEF = 10;

    // Field widths fixed by the interface.
    localparam int COORD_W  = 33;
    localparam int BASE_W   = 24;
    localparam int PERS_W   = 16;
    localparam int OCT_W    = 3;
    localparam int AMP_W    = 17;
    localparam int TERM_W   = 36;
    localparam int LEVEL_W  = 20;
    localparam int CFG_IDX_W = 2;

    // Register stages inside one octave lane.
    localparam int LANE_LAT = 19;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_OCTAVE_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_FREQUENCY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PERSISTENCE    = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [OCT_W-1:0]  OCTAVE_COUNT_RST   = 3'd2;
    localparam logic [BASE_W-1:0] BASE_FREQUENCY_RST = 24'd49152;
    localparam logic [PERS_W-1:0] PERSISTENCE_RST    = 16'd32768;

    // Shifted sample point handed to every octave lane.
    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        coord_t xs;
        coord_t ys;
    } point_t;

endpackage

### rtl/core/value_noise_2d_octaves_core.sv
// Two-dimensional value noise over up to MAX_OCTAVES octaves, one point per transfer.
// A point passes the offset register, the parallel octave lanes and the sum, magnitude and
// rounding registers before done; the depth is set by the hash multiplier chain and the blends.
// Throughput: one point per clock cycle, sustained; busy stays low.
// Reset: rst_n clears the valid pipeline and loads the register defaults.
// The result is on noise_level for the one cycle that done is high; it cannot be held.
module value_noise_2d_octaves_core #(
    parameter int MAX_OCTAVES    = vnoise_pkg::MAX_OCTAVES_DEF,
    parameter int COS_TABLE_BITS = vnoise_pkg::COS_TABLE_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [31:0]                  x_coord,
    input  logic signed [31:0]                  y_coord,
    input  logic signed [31:0]                  offset,
    output logic                                done,
    output logic [vnoise_pkg::LEVEL_W-1:0]      noise_level,
    input  logic                                cfg_we,
    input  logic [vnoise_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [vnoise_pkg::BASE_W-1:0]       cfg_data
);
    import vnoise_pkg::*;

    localparam int PIPE_LAT = 1 + LANE_LAT + 3;
    localparam int TOT_W    = TERM_W + $clog2(MAX_OCTAVES + 1);
    localparam int RND_W    = TOT_W - 17;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;

    logic                 accept;
    logic [OCT_W-1:0]     octave_count_reg;
    logic [BASE_W-1:0]    base_frequency_reg;
    logic [PERS_W-1:0]    persistence_reg;
    logic [PIPE_LAT-1:0]  vld_reg;
    point_t               point_reg;
    logic [AMP_W-1:0]     amp_reg [MAX_OCTAVES];
    logic [MAX_OCTAVES-1:0] lane_en;
    logic signed [TERM_W-1:0] term [MAX_OCTAVES];
    logic signed [TOT_W-1:0]  total_next;
    logic signed [TOT_W-1:0]  total_reg;
    logic [TOT_W-1:0]     mag_reg;
    logic [RND_W-1:0]     rnd;
    logic [LEVEL_W-1:0]   noise_level_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            octave_count_reg   <= OCTAVE_COUNT_RST;
            base_frequency_reg <= BASE_FREQUENCY_RST;
            persistence_reg    <= PERSISTENCE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_OCTAVE_COUNT:   octave_count_reg   <= cfg_data[OCT_W-1:0];
                CFG_BASE_FREQUENCY: base_frequency_reg <= cfg_data;
                CFG_PERSISTENCE:    persistence_reg    <= cfg_data[PERS_W-1:0];
                default:            ;
            endcase
        end
    end

    // Valid bits travel alongside the data through every stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[PIPE_LAT-2:0], accept};
        end
    end

    // Offset added to both coordinates.
    always_ff @(posedge clk)
    begin
        point_reg.xs <= COORD_W'(x_coord) + COORD_W'(offset);
        point_reg.ys <= COORD_W'(y_coord) + COORD_W'(offset);
    end

    // Octave amplitudes, one multiply per stage; settled long before any term needs them.
    always_ff @(posedge clk)
    begin
        amp_reg[0] <= AMP_W'(65536);
        for (int o = 1; o < MAX_OCTAVES; o++)
        begin
            amp_reg[o] <= AMP_W'((34'(amp_reg[o-1]) * 34'(persistence_reg) + 34'd32768) >> 16);
        end
    end

    // A lane contributes only when its octave is below the octave count.
    always_comb
    begin
        for (int o = 0; o < MAX_OCTAVES; o++)
        begin
            lane_en[o] = (4'(octave_count_reg) > 4'(o));
        end
    end

    for (genvar g = 0; g < MAX_OCTAVES; g++)
    begin : g_lane
        vnoise_octave_lane #(
            .LANE           (g),
            .MAX_OCTAVES    (MAX_OCTAVES),
            .COS_TABLE_BITS (COS_TABLE_BITS)
        ) u_lane (
            .clk            (clk),
            .point          (point_reg),
            .base_frequency (base_frequency_reg),
            .amp            (amp_reg[g]),
            .en             (lane_en[g]),
            .term           (term[g])
        );
    end

    // Sum of the octave terms.
    always_comb
    begin
        total_next = '0;
        for (int o = 0; o < MAX_OCTAVES; o++)
        begin
            total_next = total_next + TOT_W'(term[o]);
        end
        rnd = RND_W'((mag_reg + TOT_W'(1 << 17)) >> 18);
    end

    // Magnitude, rounding to Q4.16 and saturation.
    always_ff @(posedge clk)
    begin
        total_reg       <= total_next;
        mag_reg         <= total_reg[TOT_W-1] ? TOT_W'(-total_reg) : TOT_W'(total_reg);
        noise_level_reg <= (rnd > RND_W'(LEVEL_MAX)) ? LEVEL_MAX : LEVEL_W'(rnd);
    end

    assign done        = vld_reg[PIPE_LAT-1];
    assign noise_level = noise_level_reg;

    // Every accepted point gives its result after the fixed pipeline depth.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##PIPE_LAT done)
        else $error("accepted point did not produce a result in time");

    // No result appears without a transfer the pipeline depth earlier.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, PIPE_LAT))
        else $error("result strobe without a matching transfer");

    // With no octaves enabled, every lane term is suppressed.
    a_zero_octaves: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(octave_count_reg, 2) == '0) |-> (total_reg == '0))
        else $error("octave sum not zero with octave count of zero");

endmodule

### rtl/core/vnoise_octave_lane.sv
module vnoise_octave_lane #(
    parameter int LANE           = 0,
    parameter int MAX_OCTAVES    = 4,
    parameter int COS_TABLE_BITS = 10
) (
    input  logic                                clk,
    input  vnoise_pkg::point_t                  point,
    input  logic [vnoise_pkg::BASE_W-1:0]       base_frequency,
    input  logic [vnoise_pkg::AMP_W-1:0]        amp,
    input  logic                                en,
    output logic signed [vnoise_pkg::TERM_W-1:0] term
);
    import vnoise_pkg::*;

    localparam int FREQ_W    = BASE_W + MAX_OCTAVES - 1;
    localparam int PH_W      = 17 + FREQ_W;
    localparam int PL_W      = 16 + FREQ_W;
    localparam int TBL_DEPTH = (1 << COS_TABLE_BITS) + 1;
    localparam int ADDR_W    = COS_TABLE_BITS + 1;
    localparam int SH        = 16 - COS_TABLE_BITS;
    localparam logic [16:0] HALF_STEP = (SH == 0) ? 17'd0 : 17'(1 << (SH - 1));
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic signed [63:0] ONE_Q30 = 64'sd1073741824;

    typedef logic [16:0] wrom_t [TBL_DEPTH];

    // Blend weights sin^2(pi*i/2^(bits+1)) in Q.16, by a Q.30 sine series.
    function automatic wrom_t build_rom();
        wrom_t r;
        logic [63:0] u;
        logic [63:0] u2;
        logic [63:0] tm;
        logic signed [63:0] acc;
        logic [63:0] sq;
        for (int i = 0; i < TBL_DEPTH; i++) begin
            u   = (64'(i) * HALF_PI_Q30 + (64'd1 << (COS_TABLE_BITS - 1))) >> COS_TABLE_BITS;
            u2  = (u * u) >> 30;
            tm  = u;
            acc = $signed(u);
            tm = ((tm * u2) >> 30) / 6;   acc = acc - $signed(tm);
            tm = ((tm * u2) >> 30) / 20;  acc = acc + $signed(tm);
            tm = ((tm * u2) >> 30) / 42;  acc = acc - $signed(tm);
            tm = ((tm * u2) >> 30) / 72;  acc = acc + $signed(tm);
            tm = ((tm * u2) >> 30) / 110; acc = acc - $signed(tm);
            tm = ((tm * u2) >> 30) / 156; acc = acc + $signed(tm);
            tm = ((tm * u2) >> 30) / 210; acc = acc - $signed(tm);
            tm = ((tm * u2) >> 30) / 272; acc = acc + $signed(tm);
            tm = ((tm * u2) >> 30) / 342; acc = acc - $signed(tm);
            tm = ((tm * u2) >> 30) / 420; acc = acc + $signed(tm);
            tm = ((tm * u2) >> 30) / 506; acc = acc - $signed(tm);
            tm = ((tm * u2) >> 30) / 600; acc = acc + $signed(tm);
            if (acc < 0) begin
                acc = 0;
            end
            if (acc > ONE_Q30) begin
                acc = ONE_Q30;
            end
            sq   = $unsigned(acc) * $unsigned(acc);
            r[i] = 17'((sq + (64'd1 << 43)) >> 44);
        end
        return r;
    endfunction

    localparam wrom_t W_ROM = build_rom();

    // Axis 0 is x, axis 1 is y.
    logic [COORD_W-1:0] mag [2];
    logic [FREQ_W-1:0]  freq;
    logic [PH_W-1:0]    hi_reg [2];
    logic [PL_W-1:0]    lo_reg [2];
    logic               neg1_reg [2];
    logic [63:0]        m_reg [2];
    logic               neg2_reg [2];
    logic [16:0]        fsum [2];
    logic [ADDR_W-1:0]  waddr [2];
    logic [31:0]        ip_reg [2];
    logic [16:0]        w_reg [2];

    // Scale both coordinate magnitudes by the octave frequency in two halves.
    always_comb
    begin
        freq = FREQ_W'(base_frequency) << LANE;
        mag[0] = point.xs[COORD_W-1] ? COORD_W'(-point.xs) : COORD_W'(point.xs);
        mag[1] = point.ys[COORD_W-1] ? COORD_W'(-point.ys) : COORD_W'(point.ys);
    end

    always_ff @(posedge clk)
    begin
        for (int a = 0; a < 2; a++)
        begin
            hi_reg[a]   <= PH_W'(mag[a][32:16]) * PH_W'(freq);
            lo_reg[a]   <= PL_W'(mag[a][15:0]) * PL_W'(freq);
            m_reg[a]    <= (64'(hi_reg[a]) << 16) + 64'(lo_reg[a]);
            neg2_reg[a] <= neg1_reg[a];
        end
        neg1_reg[0] <= point.xs[COORD_W-1];
        neg1_reg[1] <= point.ys[COORD_W-1];
    end

    // Fraction index into the weight ROM, rounded with ties up.
    always_comb
    begin
        for (int a = 0; a < 2; a++)
        begin
            fsum[a]  = {1'b0, m_reg[a][31:16]} + HALF_STEP;
            waddr[a] = ADDR_W'(fsum[a] >> SH);
        end
    end

    // Lattice position, truncated toward zero, and the registered ROM reads.
    always_ff @(posedge clk)
    begin
        for (int a = 0; a < 2; a++)
        begin
            ip_reg[a] <= neg2_reg[a] ? (32'd0 - m_reg[a][63:32]) : m_reg[a][63:32];
            w_reg[a]  <= W_ROM[waddr[a]];
        end
    end

    // The weights travel with the corner values until the blends use them.
    logic [16:0] wx_d [8];
    logic [16:0] wy_d [11];

    always_ff @(posedge clk)
    begin
        wx_d[0] <= w_reg[0];
        wy_d[0] <= w_reg[1];
        for (int k = 1; k < 8; k++)
        begin
            wx_d[k] <= wx_d[k-1];
        end
        for (int k = 1; k < 11; k++)
        begin
            wy_d[k] <= wy_d[k-1];
        end
    end

    // Hash of the four by four neighbourhood, offsets -1 to +2 on each axis.
    logic [31:0] xi_reg [4];
    logic [31:0] yk_reg [4];
    logic [31:0] n0 [4][4];
    logic [31:0] n_reg [4][4];
    logic [31:0] sq_reg [4][4];
    logic [31:0] n6_reg [4][4];
    logic [31:0] t_reg [4][4];
    logic [31:0] n7_reg [4][4];
    logic [31:0] u_reg [4][4];
    logic [31:0] hs [4][4];
    logic signed [31:0] h_reg [4][4];

    always_comb
    begin
        for (int dy = 0; dy < 4; dy++)
        begin
            for (int dx = 0; dx < 4; dx++)
            begin
                n0[dy][dx] = xi_reg[dx] + yk_reg[dy];
                hs[dy][dx] = u_reg[dy][dx] + 32'd1376312589;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int d = 0; d < 4; d++)
        begin
            xi_reg[d] <= ip_reg[0] + 32'(d) - 32'd1;
            yk_reg[d] <= (ip_reg[1] + 32'(d) - 32'd1) * 32'd57;
        end
        for (int dy = 0; dy < 4; dy++)
        begin
            for (int dx = 0; dx < 4; dx++)
            begin
                n_reg[dy][dx]  <= (n0[dy][dx] << 13) ^ n0[dy][dx];
                sq_reg[dy][dx] <= n_reg[dy][dx] * n_reg[dy][dx];
                n6_reg[dy][dx] <= n_reg[dy][dx];
                t_reg[dy][dx]  <= sq_reg[dy][dx] * 32'd15731 + 32'd789221;
                n7_reg[dy][dx] <= n6_reg[dy][dx];
                u_reg[dy][dx]  <= n7_reg[dy][dx] * t_reg[dy][dx];
                h_reg[dy][dx]  <= 32'sd1073741824 - $signed({1'b0, hs[dy][dx][30:0]});
            end
        end
    end

    // Smoothing over three by three at each of the four cell corners.
    logic signed [33:0] diag_reg [2][2];
    logic signed [33:0] side_reg [2][2];
    logic signed [31:0] cen_reg [2][2];
    logic signed [35:0] s_reg [2][2];

    always_ff @(posedge clk)
    begin
        for (int cy = 0; cy < 2; cy++)
        begin
            for (int cx = 0; cx < 2; cx++)
            begin
                diag_reg[cy][cx] <= 34'(h_reg[cy][cx]) + 34'(h_reg[cy][cx+2])
                                  + 34'(h_reg[cy+2][cx]) + 34'(h_reg[cy+2][cx+2]);
                side_reg[cy][cx] <= 34'(h_reg[cy+1][cx]) + 34'(h_reg[cy+1][cx+2])
                                  + 34'(h_reg[cy][cx+1]) + 34'(h_reg[cy+2][cx+1]);
                cen_reg[cy][cx]  <= h_reg[cy+1][cx+1];
                s_reg[cy][cx]    <= 36'(diag_reg[cy][cx]) + (36'(side_reg[cy][cx]) <<< 1)
                                  + (36'(cen_reg[cy][cx]) <<< 2);
            end
        end
    end

    // Cosine blend along x on both rows, then along y.
    logic signed [17:0] wx_s;
    logic signed [17:0] wxc_s;
    logic signed [17:0] wy_s;
    logic signed [17:0] wyc_s;
    logic signed [53:0] pa_reg [2];
    logic signed [53:0] pb_reg [2];
    logic signed [54:0] r_reg [2];
    logic signed [54:0] rr [2];
    logic signed [35:0] i_reg [2];
    logic signed [53:0] qa_reg;
    logic signed [53:0] qb_reg;
    logic signed [54:0] qs_reg;
    logic signed [54:0] qr;
    logic signed [35:0] val_reg;
    logic signed [53:0] vp_reg;
    logic signed [53:0] vr;
    logic signed [TERM_W-1:0] term_reg;

    always_comb
    begin
        wx_s  = $signed({1'b0, wx_d[7]});
        wxc_s = $signed({1'b0, 17'd65536 - wx_d[7]});
        wy_s  = $signed({1'b0, wy_d[10]});
        wyc_s = $signed({1'b0, 17'd65536 - wy_d[10]});
        // Rounding by 2^16 with ties away from zero.
        for (int r = 0; r < 2; r++)
        begin
            rr[r] = r_reg[r] + (r_reg[r][54] ? 55'sd32767 : 55'sd32768);
        end
        qr = qs_reg + (qs_reg[54] ? 55'sd32767 : 55'sd32768);
        vr = vp_reg + (vp_reg[53] ? 54'sd32767 : 54'sd32768);
    end

    always_ff @(posedge clk)
    begin
        for (int r = 0; r < 2; r++)
        begin
            pa_reg[r] <= s_reg[r][0] * wxc_s;
            pb_reg[r] <= s_reg[r][1] * wx_s;
            r_reg[r]  <= 55'(pa_reg[r]) + 55'(pb_reg[r]);
            i_reg[r]  <= 36'(rr[r] >>> 16);
        end
        qa_reg   <= i_reg[0] * wyc_s;
        qb_reg   <= i_reg[1] * wy_s;
        qs_reg   <= 55'(qa_reg) + 55'(qb_reg);
        val_reg  <= 36'(qr >>> 16);
        vp_reg   <= val_reg * $signed({1'b0, amp});
        term_reg <= en ? TERM_W'(vr >>> 16) : '0;
    end

    assign term = term_reg;

endmodule
